[rtl/imu_dfr_pkg.sv]
// Package for the IMU frame deframer: widths, frame layout constants,
// queue entry type, back-end states and the raw reading decode.
// No dependencies.
`default_nettype none

package imu_dfr_pkg;

  localparam int unsigned FrameBytesDef = 43;
  localparam int unsigned AccWidthDef   = 24;
  localparam int unsigned CmdqDepthDef  = 2;

  localparam int unsigned TsW   = 34;
  localparam int unsigned ValW  = 24;
  localparam int unsigned GrpW  = 3;
  localparam int unsigned RawW  = 18;
  localparam int unsigned BufW  = 48;
  localparam int unsigned CntW  = 3;

  localparam int unsigned FirstDataByte = 6;
  localparam int unsigned GroupBytes    = 6;

  localparam logic [GrpW-1:0] GrpAccel = 3'd0;
  localparam logic [GrpW-1:0] GrpLast  = 3'd5;

  localparam logic signed [RawW-1:0] RawBias = 18'sd33024;

  typedef struct packed {
    logic           clear;
    logic           emit;
    logic [TsW-1:0] ts;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } back_state_e;

  // (hi - 1) * 256 + lo - 32768
  function automatic logic signed [RawW-1:0] raw16(input logic [7:0] hi, input logic [7:0] lo);
    return $signed({2'b00, hi, lo}) - RawBias;
  endfunction

endpackage

`default_nettype wire

[rtl/imu_dfr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module imu_dfr_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 43,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/imu_dfr_front.sv]
// Front end of the IMU deframer: byte framing, checksum, time assembly.
// Writes frame bytes to the frame RAM and pushes commands; uses imu_dfr_pkg.
`default_nettype none

module imu_dfr_front
  import imu_dfr_pkg::*;
#(
  parameter  int unsigned FRAME_BYTES = FrameBytesDef,
  localparam int unsigned AW          = $clog2(FRAME_BYTES)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          clear_accel_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output cmd_t               q_data_o,
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output logic [7:0]         ram_wdata_o,
  input  wire logic          frame_done_i
);

  localparam logic [AW-1:0] LastIdx = AW'(FRAME_BYTES - 1);

  logic [AW-1:0]  count_q, count_d;
  logic [7:0]     sum_q, sum_d;
  logic [TsW-1:0] ts_q, ts_d;
  logic           flag_q, flag_d;
  logic           busy_q, busy_d;
  logic           take;
  logic           good;
  logic [7:0]     check;

  assign in_stall_o = q_full_i || busy_q;
  assign take       = in_valid_i && !in_stall_o;
  assign check      = (sum_q == 8'd0) ? 8'd1 : sum_q;

  always_comb begin
    count_d     = count_q;
    sum_d       = sum_q;
    ts_d        = ts_q;
    flag_d      = flag_q;
    busy_d      = busy_q && !frame_done_i;
    good        = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = count_q;
    ram_wdata_o = rx_byte_i;
    if (take) begin
      if (rx_byte_i == 8'd0) begin
        count_d     = AW'(1);
        sum_d       = 8'd0;
        ram_we_o    = 1'b1;
        ram_waddr_o = '0;
      end else if (count_q != '0) begin
        if (count_q == LastIdx) begin
          count_d = '0;
          good    = (rx_byte_i == check) && !flag_q;
          if (good) begin
            busy_d = 1'b1;
          end
        end else begin
          ram_we_o = 1'b1;
          sum_d    = sum_q + rx_byte_i;
          count_d  = count_q + AW'(1);
          if (count_q == AW'(1)) begin
            ts_d[33:28] = rx_byte_i[5:0];
            flag_d      = rx_byte_i[6];
          end
          if (count_q == AW'(2)) ts_d[27:21] = rx_byte_i[6:0];
          if (count_q == AW'(3)) ts_d[20:14] = rx_byte_i[6:0];
          if (count_q == AW'(4)) ts_d[13:7]  = rx_byte_i[6:0];
          if (count_q == AW'(5)) ts_d[6:0]   = rx_byte_i[6:0];
        end
      end
    end
  end

  assign q_push_o       = take && (clear_accel_i || good);
  assign q_data_o.clear = clear_accel_i;
  assign q_data_o.emit  = good;
  assign q_data_o.ts    = ts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      flag_q  <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      flag_q  <= flag_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ts_q <= ts_d;
  end

endmodule

`default_nettype wire

[rtl/imu_dfr_cmdq.sv]
// Short command queue between the deframer front and back ends.
// Uses cmd_t from imu_dfr_pkg.
`default_nettype none

module imu_dfr_cmdq
  import imu_dfr_pkg::*;
#(
  parameter  int unsigned DEPTH = CmdqDepthDef,
  localparam int unsigned PW    = $clog2(DEPTH),
  localparam int unsigned NW    = $clog2(DEPTH + 1)
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      data_o
);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] num_q;
  logic          do_push, do_pop;

  assign full_o  = (num_q == NW'(DEPTH));
  assign valid_o = (num_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      num_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        num_q <= num_q + NW'(1);
      end else if (do_pop && !do_push) begin
        num_q <= num_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/imu_dfr_back.sv]
// Back end of the IMU deframer: reads a stored frame group by group,
// decodes readings, keeps the saturating acceleration sums, drives results.
// Uses imu_dfr_pkg.
`default_nettype none

module imu_dfr_back
  import imu_dfr_pkg::*;
#(
  parameter  int unsigned FRAME_BYTES = FrameBytesDef,
  parameter  int unsigned ACC_WIDTH   = AccWidthDef,
  localparam int unsigned AW          = $clog2(FRAME_BYTES)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_valid_i,
  input  cmd_t                       q_data_i,
  output logic                       q_pop_o,
  output logic                       ram_re_o,
  output logic [AW-1:0]              ram_raddr_o,
  input  wire logic [7:0]            ram_rdata_i,
  output logic                       frame_done_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [GrpW-1:0]            group_o,
  output logic [TsW-1:0]             time_stamp_o,
  output logic signed [ValW-1:0]     value_a_o,
  output logic signed [ValW-1:0]     value_b_o,
  output logic signed [ValW-1:0]     value_c_o,
  output logic                       last_of_frame_o
);

  localparam int unsigned SW = ((ACC_WIDTH > RawW) ? ACC_WIDTH : RawW) + 1;
  localparam int unsigned EW = (ACC_WIDTH > ValW) ? ACC_WIDTH : ValW;
  localparam logic signed [SW-1:0] AccMax =
    SW'(signed'({1'b0, {(ACC_WIDTH - 1){1'b1}}}));
  localparam logic signed [SW-1:0] AccMin =
    SW'(signed'({1'b1, {(ACC_WIDTH - 1){1'b0}}}));

  back_state_e state_q, state_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [GrpW-1:0]              grp_q, grp_d;
  logic [AW-1:0]                raddr_q, raddr_d;
  logic [BufW-1:0]              buf_q, buf_d;
  logic [TsW-1:0]               ts_q, ts_d;
  logic signed [ACC_WIDTH-1:0]  acc_q [3];
  logic signed [ACC_WIDTH-1:0]  acc_d [3];
  logic signed [RawW-1:0]       raw [3];
  logic signed [SW-1:0]         sum [3];
  logic signed [ACC_WIDTH-1:0]  sat [3];
  logic signed [EW-1:0]         sat_ext [3];
  logic signed [ValW-1:0]       val [3];
  logic                         out_free;
  logic                         load;

  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      raw[i] = raw16(buf_q[BufW-1-16*i -: 8], buf_q[BufW-9-16*i -: 8]);
      sum[i] = SW'(acc_q[i]) + SW'(raw[i]);
      if (sum[i] > AccMax) begin
        sat[i] = AccMax[ACC_WIDTH-1:0];
      end else if (sum[i] < AccMin) begin
        sat[i] = AccMin[ACC_WIDTH-1:0];
      end else begin
        sat[i] = sum[i][ACC_WIDTH-1:0];
      end
      sat_ext[i] = EW'(sat[i]);
      val[i] = (grp_q == GrpAccel) ? sat_ext[i][ValW-1:0] : ValW'(raw[i]);
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    grp_d        = grp_q;
    raddr_d      = raddr_q;
    buf_d        = buf_q;
    ts_d         = ts_q;
    acc_d        = acc_q;
    q_pop_o      = 1'b0;
    ram_re_o     = 1'b0;
    frame_done_o = 1'b0;
    load         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_data_i.clear) begin
            for (int i = 0; i < 3; i++) acc_d[i] = '0;
          end
          if (q_data_i.emit) begin
            state_d = ST_READ;
            raddr_d = AW'(FirstDataByte);
            cnt_d   = '0;
            grp_d   = GrpAccel;
            ts_d    = q_data_i.ts;
          end
        end
      end
      ST_READ: begin
        if (cnt_q < CntW'(GroupBytes)) begin
          ram_re_o = 1'b1;
          raddr_d  = raddr_q + AW'(1);
        end
        if (cnt_q != '0) begin
          buf_d = {buf_q[BufW-9:0], ram_rdata_i};
        end
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(GroupBytes)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if (grp_q == GrpAccel) begin
            acc_d = sat;
          end
          if (grp_q == GrpLast) begin
            frame_done_o = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            grp_d   = grp_q + GrpW'(1);
            cnt_d   = '0;
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign ram_raddr_o = raddr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      grp_q       <= '0;
      raddr_q     <= '0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < 3; i++) acc_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      grp_q       <= grp_d;
      raddr_q     <= raddr_d;
      out_valid_o <= load || (out_valid_o && out_stall_i);
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    ts_q  <= ts_d;
    if (load) begin
      group_o         <= grp_q;
      time_stamp_o    <= ts_q;
      value_a_o       <= val[0];
      value_b_o       <= val[1];
      value_c_o       <= val[2];
      last_of_frame_o <= (grp_q == GrpLast);
    end
  end

endmodule

`default_nettype wire

[rtl/imu_frame_deframer.sv]
// IMU frame deframer, top level. Takes one received byte per transfer while
// not stalled. After the checksum byte of a good data frame the input stalls
// while the six results are produced: the back end pops the command, then
// reads the 36 reading bytes from the single read port of the frame RAM, six
// bytes per result, reading a group and then loading its result. The input
// stays stalled until the last result is loaded, plus any output stall.
// Acceleration sums saturate and persist until a transfer with clear_accel_i
// set. Depends on imu_dfr_pkg and the front, queue, back and RAM modules.
`default_nettype none

module imu_frame_deframer
  import imu_dfr_pkg::*;
#(
  parameter  int unsigned FRAME_BYTES = FrameBytesDef,
  parameter  int unsigned ACC_WIDTH   = AccWidthDef,
  localparam int unsigned AW          = $clog2(FRAME_BYTES)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              clear_accel_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [GrpW-1:0]        group_o,
  output logic [TsW-1:0]         time_stamp_o,
  output logic signed [ValW-1:0] value_a_o,
  output logic signed [ValW-1:0] value_b_o,
  output logic signed [ValW-1:0] value_c_o,
  output logic                   last_of_frame_o
);

  cmd_t          push_data, pop_data;
  logic          q_full, q_push, q_valid, q_pop;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          frame_done;

  imu_dfr_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .clear_accel_i(clear_accel_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (push_data),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .frame_done_i (frame_done)
  );

  imu_dfr_cmdq #(
    .DEPTH(CmdqDepthDef)
  ) u_cmdq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(push_data),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .data_o     (pop_data)
  );

  imu_dfr_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  imu_dfr_back #(
    .FRAME_BYTES(FRAME_BYTES),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (pop_data),
    .q_pop_o        (q_pop),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .frame_done_o   (frame_done),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .group_o        (group_o),
    .time_stamp_o   (time_stamp_o),
    .value_a_o      (value_a_o),
    .value_b_o      (value_b_o),
    .value_c_o      (value_c_o),
    .last_of_frame_o(last_of_frame_o)
  );

endmodule

`default_nettype wire

[rtl/imu_dfr_checker.sv]
// Port-level checker for the IMU frame deframer, bound to the top level.
// Uses imu_dfr_pkg.
`default_nettype none

module imu_dfr_checker
  import imu_dfr_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [GrpW-1:0]   group_o,
  input wire logic [TsW-1:0]    time_stamp_o,
  input wire logic [ValW-1:0]   value_a_o,
  input wire logic [ValW-1:0]   value_b_o,
  input wire logic [ValW-1:0]   value_c_o,
  input wire logic              last_of_frame_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(group_o) && $stable(time_stamp_o) &&
      $stable(value_a_o) && $stable(value_b_o) && $stable(value_c_o) &&
      $stable(last_of_frame_o))
    else $error("result changed while stalled");

  a_last_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (group_o <= GrpLast) && (last_of_frame_o == (group_o == GrpLast)))
    else $error("group and end-of-frame flag disagree");

  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (group_o != GrpLast) |-> in_stall_o)
    else $error("input taken in the middle of a frame's results");

endmodule

bind imu_frame_deframer imu_dfr_checker u_checker (.*);

`default_nettype wire

[sim/tb_top.sv]
// Testbench for imu_frame_deframer: drives serial bytes and checks every result
// against a shadow deframer kept in the bench. Depends on imu_dfr_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
  import imu_dfr_pkg::*;

  localparam int     FrameLen    = FrameBytesDef;
  localparam int     CheckIdx    = FrameLen - 1;
  localparam longint AccMax      = (longint'(1) << (AccWidthDef - 1)) - 1;
  localparam longint AccMin      = -AccMax - 1;
  localparam int     HoldCycles  = 400;
  localparam int     DrainCycles = 60;
  localparam int     EndCycles   = 100;
  localparam int     StallLimit  = 3000;

  typedef struct packed {
    logic [GrpW-1:0]        grp;
    logic [TsW-1:0]         ts;
    logic signed [ValW-1:0] va;
    logic signed [ValW-1:0] vb;
    logic signed [ValW-1:0] vc;
    logic                   last;
  } imu_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [7:0]             rx_byte_i;
  logic                   clear_accel_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [GrpW-1:0]        group_o;
  logic [TsW-1:0]         time_stamp_o;
  logic signed [ValW-1:0] value_a_o;
  logic signed [ValW-1:0] value_b_o;
  logic signed [ValW-1:0] value_c_o;
  logic                   last_of_frame_o;

  imu_frame_deframer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .clear_accel_i  (clear_accel_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .group_o        (group_o),
    .time_stamp_o   (time_stamp_o),
    .value_a_o      (value_a_o),
    .value_b_o      (value_b_o),
    .value_c_o      (value_c_o),
    .last_of_frame_o(last_of_frame_o)
  );

  int src_idle_pct;
  int sink_stall_pct;
  int clear_pct;
  bit hold_req;
  bit holding;
  int n_err;
  int n_bytes;
  int n_results;
  int n_frames;
  int idle_cycles;

  logic [7:0]  shadow_store [0:63];
  int          shadow_count;
  logic [7:0]  shadow_sum;
  longint      shadow_accel [3];
  imu_result_t pending_results [$];
  imu_result_t want_r;

  logic [7:0] frame_buf [0:FrameLen-1];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int raw_reading(input int at);
    return (int'(shadow_store[at]) - 1) * 256 + int'(shadow_store[at + 1]) - 32768;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic clr);
    imu_result_t    r;
    logic [TsW-1:0] ts;
    logic [7:0]     chk;
    longint         s;
    int             base;
    if (clr) begin
      for (int i = 0; i < 3; i++) shadow_accel[i] = 0;
    end
    if (b == 8'h00) begin
      shadow_store[0] = 8'h00;
      shadow_count = 1;
      shadow_sum = 8'h00;
      return;
    end
    if (shadow_count == 0) return;
    if (shadow_count + 1 < FrameLen) begin
      shadow_store[shadow_count] = b;
      shadow_sum = shadow_sum + b;
      shadow_count++;
      return;
    end
    shadow_count = 0;
    chk = (shadow_sum == 8'h00) ? 8'h01 : shadow_sum;
    if (b != chk) return;
    if (shadow_store[1][6]) return;
    ts = {shadow_store[1][5:0], shadow_store[2][6:0], shadow_store[3][6:0],
          shadow_store[4][6:0], shadow_store[5][6:0]};
    for (int i = 0; i < 3; i++) begin
      s = shadow_accel[i] + longint'(raw_reading(FirstDataByte + 2 * i));
      if (s > AccMax) s = AccMax;
      if (s < AccMin) s = AccMin;
      shadow_accel[i] = s;
    end
    r.grp  = GrpAccel;
    r.ts   = ts;
    r.va   = shadow_accel[0][ValW-1:0];
    r.vb   = shadow_accel[1][ValW-1:0];
    r.vc   = shadow_accel[2][ValW-1:0];
    r.last = 1'b0;
    pending_results.push_back(r);
    for (int g = 1; g < 6; g++) begin
      base   = FirstDataByte + GroupBytes * g;
      r.grp  = GrpW'(g);
      r.va   = ValW'(raw_reading(base));
      r.vb   = ValW'(raw_reading(base + 2));
      r.vc   = ValW'(raw_reading(base + 4));
      r.last = (r.grp == GrpLast);
      pending_results.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      n_err++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual group %0d ts %h",
                 $time, group_o, time_stamp_o);
        n_err++;
      end else begin
        want_r = pending_results.pop_front();
        check_field("group", want_r.grp, group_o);
        check_field("time_stamp", want_r.ts, time_stamp_o);
        check_field("value_a", want_r.va, value_a_o);
        check_field("value_b", want_r.vb, value_b_o);
        check_field("value_c", want_r.vc, value_c_o);
        check_field("last_of_frame", want_r.last, last_of_frame_o);
      end
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= holding || ($urandom_range(99) < sink_stall_pct);
    end
  end

  initial begin
    holding = 1'b0;
    forever begin
      wait (hold_req);
      holding = 1'b1;
      repeat (HoldCycles) @(negedge clk_i);
      holding  = 1'b0;
      hold_req = 1'b0;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, StallLimit);
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic logic pick_clear();
    return ($urandom_range(99) < clear_pct);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic clr);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    rx_byte_i     <= b;
    clear_accel_i <= clr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    deframe_byte(b, clr);
    n_bytes++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic void fill_frame(input logic status);
    frame_buf[0] = 8'h00;
    for (int i = 1; i < CheckIdx; i++) frame_buf[i] = 8'($urandom_range(1, 255));
    frame_buf[1][6] = status;
    if (frame_buf[1] == 8'h00) frame_buf[1] = 8'h01;
  endfunction

  function automatic void fill_const(input logic [7:0] v);
    frame_buf[0] = 8'h00;
    for (int i = 1; i < CheckIdx; i++) frame_buf[i] = v;
  endfunction

  function automatic logic [7:0] frame_check();
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 1; i < CheckIdx; i++) acc = acc + frame_buf[i];
    return (acc == 8'h00) ? 8'h01 : acc;
  endfunction

  task automatic send_frame(input logic corrupt);
    logic [7:0] good;
    good = frame_check();
    frame_buf[CheckIdx] = good;
    if (corrupt) begin
      do frame_buf[CheckIdx] = 8'($urandom_range(1, 255));
      while (frame_buf[CheckIdx] == good);
    end
    n_frames++;
    for (int i = 0; i < FrameLen; i++) send_byte(frame_buf[i], pick_clear());
  endtask

  task automatic test_stray_bytes();
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    wait_drained();
  endtask

  task automatic test_field_extremes();
    fill_const(8'hFF);
    frame_buf[1] = 8'hBF;
    send_frame(1'b0);
    wait_drained();
  endtask

  task automatic test_status_frame();
    fill_frame(1'b1);
    send_frame(1'b0);
    wait_drained();
  endtask

  task automatic test_bad_checksum();
    fill_frame(1'b0);
    send_frame(1'b1);
    wait_drained();
  endtask

  task automatic test_zero_sum_checksum();
    logic [7:0] part;
    do begin
      fill_frame(1'b0);
      part = 8'h00;
      for (int i = 1; i < CheckIdx - 1; i++) part = part + frame_buf[i];
    end while (part == 8'h00);
    frame_buf[CheckIdx - 1] = 8'h00 - part;
    send_frame(1'b0);
    wait_drained();
  endtask

  task automatic test_resync();
    send_byte(8'h00, 1'b0);
    for (int i = 0; i < 5; i++) send_byte(8'($urandom_range(1, 255)), 1'b0);
    fill_frame(1'b0);
    send_frame(1'b0);
    wait_drained();
  endtask

  task automatic test_clear_accel();
    send_byte(8'h33, 1'b1);
    fill_frame(1'b0);
    frame_buf[CheckIdx] = frame_check();
    n_frames++;
    for (int i = 0; i < FrameLen; i++) send_byte(frame_buf[i], i == CheckIdx);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    fill_frame(1'b0);
    send_frame(1'b0);
    repeat (3) send_byte(8'($urandom_range(1, 255)), 1'b0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
    int start;
    int pick;
    int k;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    clear_pct      = 3;
    start          = n_bytes;
    while (n_bytes - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        fill_frame(1'b0);
        send_frame(1'b0);
      end else if (pick < 72) begin
        fill_frame(1'b1);
        send_frame(1'b0);
      end else if (pick < 82) begin
        fill_frame(1'b0);
        send_frame(1'b1);
      end else if (pick < 92) begin
        k = $urandom_range(1, CheckIdx - 1);
        send_byte(8'h00, pick_clear());
        repeat (k) send_byte(8'($urandom_range(1, 255)), pick_clear());
      end else begin
        k = $urandom_range(1, 5);
        repeat (k) send_byte(8'($urandom_range(0, 255)), pick_clear());
      end
    end
    clear_pct = 0;
    wait_drained();
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    rx_byte_i      = 8'h00;
    clear_accel_i  = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    clear_pct      = 0;
    hold_req       = 1'b0;
    n_err          = 0;
    n_bytes        = 0;
    n_results      = 0;
    n_frames       = 0;
    shadow_count   = 0;
    shadow_sum     = 8'h00;
    for (int i = 0; i < 3; i++) shadow_accel[i] = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_stray_bytes();
    test_field_extremes();
    test_status_frame();

    src_idle_pct   = 56;
    sink_stall_pct = 0;
    test_bad_checksum();
    test_zero_sum_checksum();

    src_idle_pct   = 0;
    sink_stall_pct = 56;
    test_resync();
    test_clear_accel();

    test_random_traffic(30, 30, 20);
    test_backpressure();

    wait_drained();
    repeat (EndCycles) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      n_err += pending_results.size();
    end
    $display("tb_top: %0d bytes in %0d built frames, %0d results checked", n_bytes,
             n_frames, n_results);
    $display("tb_top: stray bytes, resync, bad sums, status frames, clears, long hold");
    if (n_err == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/imu_dfr_pkg.sv
rtl/imu_dfr_ram.sv
rtl/imu_dfr_front.sv
rtl/imu_dfr_cmdq.sv
rtl/imu_dfr_back.sv
rtl/imu_frame_deframer.sv
rtl/imu_dfr_checker.sv
sim/tb_top.sv
